### hdl/hvd_pkg.sv
// ----------------------------------------------------------------------------
// hvd_pkg
// shared types, constants and elaboration-time tables for the haversine
// distance pipeline: word type, cordic mode, arctangent table, scale factors
// ----------------------------------------------------------------------------
package hvd_pkg;

	localparam int WORD_W   = 64;
	localparam int STEPS    = 60;
	localparam int CONV_LAT = 5;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic {
		CORDIC_ROTATE,
		CORDIC_VECTOR
	} cordic_mode_t;

	typedef enum logic [1:0] {
		SER_DIV25,
		SER_DIV57121,
		SER_SHIFT
	} ser_kind_t;

	// angle units of 1e-7 degree
	localparam logic signed [31:0] QUARTER_TURN     = 32'sd900000000;
	localparam logic signed [31:0] NEG_QUARTER_TURN = -32'sd900000000;
	localparam logic signed [31:0] HALF_TURN        = 32'sd1800000000;
	localparam logic signed [33:0] HALF_TURN_W      = 34'sd1800000000;
	localparam logic signed [33:0] NEG_HALF_TURN_W  = -34'sd1800000000;
	localparam logic signed [33:0] FULL_TURN_W      = 34'sd3600000000;

	localparam word_t            UNIT_Q56        = 64'sh0100_0000_0000_0000;
	localparam logic [33:0]      TWICE_RADIUS_MM = 34'd12742000000;

	// truncating arctangent series in q62, evaluated at elaboration only
	function automatic logic [63:0] atan_series(input logic [63:0] p_in,
		input ser_kind_t kind, input int unsigned sh);
		logic [63:0] sum;
		logic [63:0] p;
		logic [63:0] t;
		logic        done;
		sum  = '0;
		p    = p_in;
		done = 1'b0;
		for (int unsigned k = 0; k < 64; k++) begin
			if (!done && p != 64'd0) begin
				t   = p / 64'(2 * k + 1);
				sum = k[0] ? sum - t : sum + t;
				unique case (kind)
					SER_DIV25:    p = p / 64'd25;
					SER_DIV57121: p = p / 64'd57121;
					default: begin
						if (sh >= 64) begin
							done = 1'b1;
						end else begin
							p = p >> sh;
						end
					end
				endcase
			end
		end
		return sum;
	endfunction

	function automatic logic [63:0] quarter_pi_q62();
		return 64'd4 * atan_series(64'h4000_0000_0000_0000 / 64'd5, SER_DIV25, 0)
			- atan_series(64'h4000_0000_0000_0000 / 64'd239, SER_DIV57121, 0);
	endfunction

	function automatic word_t atan_entry(input int unsigned i);
		logic [63:0] v;
		if (i == 0) begin
			v = quarter_pi_q62();
		end else begin
			v = atan_series(64'd1 << (62 - i), SER_SHIFT, 2 * i);
		end
		return word_t'((v + 64'd2) >> 2);
	endfunction

	function automatic logic [63:0] rad_per_unit_q92();
		logic [63:0] pi62;
		logic [63:0] q1;
		logic [63:0] r;
		pi62 = quarter_pi_q62() << 2;
		q1   = pi62 / 64'd1800000000;
		r    = pi62 % 64'd1800000000;
		return (q1 << 30) + ((r << 30) / 64'd1800000000);
	endfunction

	localparam logic [63:0] RAD_PER_UNIT_Q92 = rad_per_unit_q92();
	localparam logic [31:0] RPU_LO           = RAD_PER_UNIT_Q92[31:0];
	localparam logic [30:0] RPU_HI           = RAD_PER_UNIT_Q92[62:32];

endpackage

### hdl/haversine_distance.sv
// ----------------------------------------------------------------------------
// haversine_distance
// great-circle distance in mm between two lat/lon points (1e-7 degree)
// throughput: one pair per cycle while the skid slot is empty, set by the fully pipelined cordic rows
// reset: clears the valid line and the output/skid flags, datapath is not reset
// ----------------------------------------------------------------------------
module haversine_distance (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [30:0] lat_a,
	input  logic signed [31:0] lon_a,
	input  logic signed [30:0] lat_b,
	input  logic signed [31:0] lon_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [34:0]        distance_mm
);
	import hvd_pkg::*;

	// register counts of each segment of the datapath
	localparam int PIPE_LAT = 1 + CONV_LAT + STEPS + 1 + STEPS + 3 + 3 * STEPS + 4;

	typedef struct packed {
		word_t zd;
		logic  fd;
		logic  f1;
		logic  f2;
	} side1_t;

	// global advance: the whole pipe moves unless the skid slot is taken
	logic adv;
	logic in_xfer;
	logic skid_valid_q;
	logic [PIPE_LAT-1:0] vld_q;

	assign adv      = !skid_valid_q;
	assign in_ready = adv;
	assign in_xfer  = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], in_xfer};
		end
	end

	// stage 1: sign extend latitudes, longitude difference folded into a half turn
	logic signed [31:0] lat1_s1, lat2_s1, dl_s1;
	logic signed [33:0] dl_raw;

	assign dl_raw = {{2{lon_b[31]}}, lon_b} - {{2{lon_a[31]}}, lon_a};

	always_ff @(posedge clk) begin
		if (adv) begin
			lat1_s1 <= {lat_a[30], lat_a};
			lat2_s1 <= {lat_b[30], lat_b};
			if (dl_raw > HALF_TURN_W) begin
				dl_s1 <= 32'(dl_raw - FULL_TURN_W);
			end else if (dl_raw < NEG_HALF_TURN_W) begin
				dl_s1 <= 32'(dl_raw + FULL_TURN_W);
			end else begin
				dl_s1 <= 32'(dl_raw);
			end
		end
	end

	// unit conversion to q60 radians, three angles in parallel
	word_t z1, z2, zd;
	logic  f1, f2, fd;

	hvd_angle_conv u_conv_lat1 (.clk(clk), .en(adv), .u(lat1_s1), .z(z1), .flip(f1));
	hvd_angle_conv u_conv_lat2 (.clk(clk), .en(adv), .u(lat2_s1), .z(z2), .flip(f2));
	hvd_angle_conv u_conv_dl   (.clk(clk), .en(adv), .u(dl_s1),   .z(zd), .flip(fd));

	// row 1: cos/sin of both latitudes; longitude angle rides alongside
	word_t  ch1_x_in [2], ch1_y_in [2], ch1_z_in [2];
	word_t  ch1_x [2], ch1_y [2], ch1_z [2];
	side1_t side1_in, side1_out;

	assign ch1_x_in[0] = UNIT_Q56;
	assign ch1_y_in[0] = '0;
	assign ch1_z_in[0] = z1;
	assign ch1_x_in[1] = UNIT_Q56;
	assign ch1_y_in[1] = '0;
	assign ch1_z_in[1] = z2;
	assign side1_in    = '{zd: zd, fd: fd, f1: f1, f2: f2};

	hvd_cordic_chain #(.LANES(2), .MODE(CORDIC_ROTATE)) u_row1 (
		.clk(clk), .en(adv),
		.x_in(ch1_x_in), .y_in(ch1_y_in), .z_in(ch1_z_in),
		.x_out(ch1_x), .y_out(ch1_y), .z_out(ch1_z)
	);

	hvd_delay #(.W($bits(side1_t)), .DEPTH(STEPS)) u_side1 (
		.clk(clk), .en(adv), .d(side1_in), .q(side1_out)
	);

	// undo the half-turn folds
	word_t c1_s, s1_s, c2_s, s2_s, zd_s;
	logic  fd_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			c1_s <= side1_out.f1 ? -ch1_x[0] : ch1_x[0];
			s1_s <= side1_out.f1 ? -ch1_y[0] : ch1_y[0];
			c2_s <= side1_out.f2 ? -ch1_x[1] : ch1_x[1];
			s2_s <= side1_out.f2 ? -ch1_y[1] : ch1_y[1];
			zd_s <= side1_out.zd;
			fd_s <= side1_out.fd;
		end
	end

	// row 2: gain on the first point's parts and s2, c2 rotated by the longitude gap
	word_t ch2_x_in [4], ch2_y_in [4], ch2_z_in [4];
	word_t ch2_x [4], ch2_y [4], ch2_z [4];
	logic  fd_d;

	assign ch2_x_in[0] = c1_s;
	assign ch2_x_in[1] = s1_s;
	assign ch2_x_in[2] = c2_s;
	assign ch2_x_in[3] = s2_s;
	assign ch2_z_in[2] = zd_s;
	for (genvar l = 0; l < 4; l++) begin : g_row2_y
		assign ch2_y_in[l] = '0;
	end
	assign ch2_z_in[0] = '0;
	assign ch2_z_in[1] = '0;
	assign ch2_z_in[3] = '0;

	hvd_cordic_chain #(.LANES(4), .MODE(CORDIC_ROTATE)) u_row2 (
		.clk(clk), .en(adv),
		.x_in(ch2_x_in), .y_in(ch2_y_in), .z_in(ch2_z_in),
		.x_out(ch2_x), .y_out(ch2_y), .z_out(ch2_z)
	);

	hvd_delay #(.W(1), .DEPTH(STEPS)) u_side2 (
		.clk(clk), .en(adv), .d(fd_s), .q(fd_d)
	);

	// unit vectors P1 = (p1x, 0, p1z), P2 = (p2x, p2y, p2z)
	word_t p1x_s, p1z_s, p2x_s, p2y_s, p2z_s;
	word_t dx_s, dz_s, sx_s, sz_s, py_s;
	word_t adx_s, adz_s, asx_s, asz_s, apy_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			p1x_s <= ch2_x[0];
			p1z_s <= ch2_x[1];
			p2x_s <= fd_d ? -ch2_x[2] : ch2_x[2];
			p2y_s <= fd_d ? -ch2_y[2] : ch2_y[2];
			p2z_s <= ch2_x[3];

			// difference and sum vectors
			dx_s <= p1x_s - p2x_s;
			dz_s <= p1z_s - p2z_s;
			sx_s <= p1x_s + p2x_s;
			sz_s <= p1z_s + p2z_s;
			py_s <= p2y_s;

			adx_s <= dx_s[WORD_W-1] ? -dx_s : dx_s;
			adz_s <= dz_s[WORD_W-1] ? -dz_s : dz_s;
			asx_s <= sx_s[WORD_W-1] ? -sx_s : sx_s;
			asz_s <= sz_s[WORD_W-1] ? -sz_s : sz_s;
			apy_s <= py_s[WORD_W-1] ? -py_s : py_s;
		end
	end

	// row 3: xy magnitudes by vectoring, z parts get the matching gain
	word_t ch3v_x_in [2], ch3v_y_in [2], ch3v_z_in [2];
	word_t ch3v_x [2], ch3v_y [2], ch3v_z [2];
	word_t ch3r_x_in [2], ch3r_y_in [2], ch3r_z_in [2];
	word_t ch3r_x [2], ch3r_y [2], ch3r_z [2];

	assign ch3v_x_in[0] = adx_s;
	assign ch3v_y_in[0] = apy_s;
	assign ch3v_x_in[1] = asx_s;
	assign ch3v_y_in[1] = apy_s;
	assign ch3r_x_in[0] = adz_s;
	assign ch3r_x_in[1] = asz_s;
	for (genvar l = 0; l < 2; l++) begin : g_row3_zero
		assign ch3v_z_in[l] = '0;
		assign ch3r_y_in[l] = '0;
		assign ch3r_z_in[l] = '0;
	end

	hvd_cordic_chain #(.LANES(2), .MODE(CORDIC_VECTOR)) u_row3_vec (
		.clk(clk), .en(adv),
		.x_in(ch3v_x_in), .y_in(ch3v_y_in), .z_in(ch3v_z_in),
		.x_out(ch3v_x), .y_out(ch3v_y), .z_out(ch3v_z)
	);

	hvd_cordic_chain #(.LANES(2), .MODE(CORDIC_ROTATE)) u_row3_gain (
		.clk(clk), .en(adv),
		.x_in(ch3r_x_in), .y_in(ch3r_y_in), .z_in(ch3r_z_in),
		.x_out(ch3r_x), .y_out(ch3r_y), .z_out(ch3r_z)
	);

	// row 4: full 3d magnitudes, |P1-P2| and |P1+P2| with equal gain
	word_t ch4_y_in [2], ch4_z_in [2];
	word_t ch4_x [2], ch4_y [2], ch4_z [2];

	assign ch4_y_in[0] = ch3r_x[0];
	assign ch4_y_in[1] = ch3r_x[1];
	assign ch4_z_in[0] = '0;
	assign ch4_z_in[1] = '0;

	hvd_cordic_chain #(.LANES(2), .MODE(CORDIC_VECTOR)) u_row4 (
		.clk(clk), .en(adv),
		.x_in(ch3v_x), .y_in(ch4_y_in), .z_in(ch4_z_in),
		.x_out(ch4_x), .y_out(ch4_y), .z_out(ch4_z)
	);

	// row 5: half central angle = atan2(|P1-P2|, |P1+P2|)
	word_t ch5_x_in [1], ch5_y_in [1], ch5_z_in [1];
	word_t ch5_x [1], ch5_y [1], ch5_z [1];

	assign ch5_x_in[0] = ch4_x[1];
	assign ch5_y_in[0] = ch4_x[0];
	assign ch5_z_in[0] = '0;

	hvd_cordic_chain #(.LANES(1), .MODE(CORDIC_VECTOR)) u_row5 (
		.clk(clk), .en(adv),
		.x_in(ch5_x_in), .y_in(ch5_y_in), .z_in(ch5_z_in),
		.x_out(ch5_x), .y_out(ch5_y), .z_out(ch5_z)
	);

	// scale by twice the radius in mm, product split in two partial products
	logic [60:0] theta_s;
	logic [65:0] plo_s;
	logic [62:0] phi_s;
	logic [94:0] prod_s;
	logic [34:0] dist_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			// coincident points can leave a tiny negative residue
			theta_s <= ch5_z[0][WORD_W-1] ? '0 : ch5_z[0][60:0];
			plo_s   <= 66'(theta_s[31:0]) * 66'(TWICE_RADIUS_MM);
			phi_s   <= 63'(theta_s[60:32]) * 63'(TWICE_RADIUS_MM);
			prod_s  <= (95'(phi_s) << 32) + 95'(plo_s);
			// q60 down to mm, rounded half up
			dist_s  <= prod_s[94:60] + 35'(prod_s[59]);
		end
	end

	// output register plus one skid slot
	logic        arrive;
	logic        out_valid_q;
	logic [34:0] dist_q;
	logic [34:0] skid_q;

	assign arrive = adv && vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (arrive) begin
			if (out_valid_q && !out_ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				dist_q <= skid_q;
			end
		end else if (arrive) begin
			if (out_valid_q && !out_ready) begin
				skid_q <= dist_s;
			end else begin
				dist_q <= dist_s;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign distance_mm = dist_q;

	// skid slot is only ever used behind a held result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid slot holds a result while output is empty");

	// skid slot fills only when the result in front is stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !out_ready))
		else $error("skid slot filled without an output stall");

	// pipe freezes while the skid slot is occupied
	a_pipe_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> vld_q == $past(vld_q))
		else $error("pipeline moved while skid slot was full");

endmodule

### hdl/hvd_cordic_cell.sv
// ----------------------------------------------------------------------------
// hvd_cordic_cell
// one registered cordic micro-rotation, fixed step index and mode
// ----------------------------------------------------------------------------
module hvd_cordic_cell #(
	parameter int                   STEP = 0,
	parameter hvd_pkg::cordic_mode_t MODE = hvd_pkg::CORDIC_ROTATE
) (
	input  logic           clk,
	input  logic           en,
	input  hvd_pkg::word_t x,
	input  hvd_pkg::word_t y,
	input  hvd_pkg::word_t z,
	output hvd_pkg::word_t x_q,
	output hvd_pkg::word_t y_q,
	output hvd_pkg::word_t z_q
);
	import hvd_pkg::*;

	localparam word_t ATAN = atan_entry(STEP);

	word_t dx;
	word_t dy;
	logic  cw;

	assign dx = y >>> STEP;
	assign dy = x >>> STEP;
	// rotation follows the residual angle, vectoring drives y toward zero
	assign cw = (MODE == CORDIC_ROTATE) ? !z[WORD_W-1] : y[WORD_W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (cw) begin
				x_q <= x - dx;
				y_q <= y + dy;
				z_q <= z - ATAN;
			end else begin
				x_q <= x + dx;
				y_q <= y - dy;
				z_q <= z + ATAN;
			end
		end
	end

endmodule

### hdl/hvd_cordic_chain.sv
// ----------------------------------------------------------------------------
// hvd_cordic_chain
// row of cordic cells, one per step, several independent lanes side by side
// ----------------------------------------------------------------------------
module hvd_cordic_chain #(
	parameter int                   LANES = 1,
	parameter hvd_pkg::cordic_mode_t MODE  = hvd_pkg::CORDIC_ROTATE
) (
	input  logic           clk,
	input  logic           en,
	input  hvd_pkg::word_t x_in  [LANES],
	input  hvd_pkg::word_t y_in  [LANES],
	input  hvd_pkg::word_t z_in  [LANES],
	output hvd_pkg::word_t x_out [LANES],
	output hvd_pkg::word_t y_out [LANES],
	output hvd_pkg::word_t z_out [LANES]
);
	import hvd_pkg::*;

	word_t xs [STEPS+1][LANES];
	word_t ys [STEPS+1][LANES];
	word_t zs [STEPS+1][LANES];

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		assign xs[0][l]  = x_in[l];
		assign ys[0][l]  = y_in[l];
		assign zs[0][l]  = z_in[l];
		assign x_out[l]  = xs[STEPS][l];
		assign y_out[l]  = ys[STEPS][l];
		assign z_out[l]  = zs[STEPS][l];

		for (genvar s = 0; s < STEPS; s++) begin : g_step
			hvd_cordic_cell #(
				.STEP(s),
				.MODE(MODE)
			) u_cell (
				.clk(clk),
				.en (en),
				.x  (xs[s][l]),
				.y  (ys[s][l]),
				.z  (zs[s][l]),
				.x_q(xs[s+1][l]),
				.y_q(ys[s+1][l]),
				.z_q(zs[s+1][l])
			);
		end
	end

endmodule

### hdl/hvd_delay.sv
// ----------------------------------------------------------------------------
// hvd_delay
// enabled shift line that carries side data alongside a cordic chain
// ----------------------------------------------------------------------------
module hvd_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] taps_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			taps_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
		end
	end

	assign q = taps_q[DEPTH-1];

endmodule

### hdl/hvd_angle_conv.sv
// ----------------------------------------------------------------------------
// hvd_angle_conv
// folds an angle in 1e-7 degree into [-90,90] and converts it to q60 radians
// ----------------------------------------------------------------------------
module hvd_angle_conv (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] u,
	output hvd_pkg::word_t     z,
	output logic               flip
);
	import hvd_pkg::*;

	logic signed [31:0] u_s1;
	logic               flip_s1;
	logic [29:0]        mag_s2;
	logic               neg_s2, flip_s2;
	logic [61:0]        plo_s3;
	logic [60:0]        phi_s3;
	logic               neg_s3, flip_s3;
	logic [61:0]        zmag_s4;
	logic               neg_s4, flip_s4;
	word_t              z_s5;
	logic               flip_s5;
	logic signed [31:0] neg_u;
	word_t              zw;

	assign neg_u = -u_s1;
	assign zw    = word_t'({2'b00, zmag_s4});

	always_ff @(posedge clk) begin
		if (en) begin
			// half-turn fold, the rotated vector is negated afterwards
			if (u > QUARTER_TURN) begin
				u_s1    <= u - HALF_TURN;
				flip_s1 <= 1'b1;
			end else if (u < NEG_QUARTER_TURN) begin
				u_s1    <= u + HALF_TURN;
				flip_s1 <= 1'b1;
			end else begin
				u_s1    <= u;
				flip_s1 <= 1'b0;
			end

			neg_s2  <= u_s1[31];
			mag_s2  <= u_s1[31] ? neg_u[29:0] : u_s1[29:0];
			flip_s2 <= flip_s1;

			plo_s3  <= 62'(mag_s2) * 62'(RPU_LO);
			phi_s3  <= 61'(mag_s2) * 61'(RPU_HI);
			neg_s3  <= neg_s2;
			flip_s3 <= flip_s2;

			// product shifted down 32 bits, rounded half up
			zmag_s4 <= 62'(phi_s3) + 62'(plo_s3[61:32]) + 62'(plo_s3[31]);
			neg_s4  <= neg_s3;
			flip_s4 <= flip_s3;

			z_s5    <= neg_s4 ? -zw : zw;
			flip_s5 <= flip_s4;
		end
	end

	assign z    = z_s5;
	assign flip = flip_s5;

endmodule
